// ----- rtl/sbusrx_pkg.sv -----
// Shared types and constants for the serial bus frame receiver.
package sbusrx_pkg;

    localparam logic [7:0]  START_BYTE    = 8'h0F;
    localparam logic [4:0]  FRAME_LEN     = 5'd25;
    localparam int          STORE_DEPTH   = 23;
    localparam int          BYTE_W        = 8;
    localparam int          CHAN_W        = 11;
    localparam logic [4:0]  NUM_PACKED    = 5'd16;
    localparam logic [4:0]  DIGITAL_CH_A  = 5'd16;
    localparam logic [4:0]  LAST_CHANNEL  = 5'd17;
    localparam logic [10:0] DIGITAL_LOW   = 11'd173;
    localparam logic [10:0] DIGITAL_HIGH  = 11'd1812;
    localparam logic [11:0] PULSE_OFFSET  = 12'd880;
    localparam logic [15:0] GAP_RESET     = 16'd3500;

    localparam int FLAG_CH16        = 0;
    localparam int FLAG_CH17        = 1;
    localparam int FLAG_SIGNAL_LOSS = 2;
    localparam int FLAG_FAILSAFE    = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_CALC,
        ST_OUT
    } state_t;

endpackage

// ----- rtl/sbusrx_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module sbusrx_ram
    import sbusrx_pkg::*;
#(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = STORE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/sbus_frame_receiver.sv -----
// Serial bus frame receiver: collects 25-byte frames and emits 18 channel items.
// Bytes are taken one per cycle while no frame is being unpacked.
// After the 25th byte, the frame store is read back one byte at a time
// through a shift accumulator; the burst of 18 items can be held up by any
// output stall, and no byte is taken meanwhile.
// Reset (asynchronous, active low) clears position and start time and loads the gap limit with 3500.
module sbus_frame_receiver
    import sbusrx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] time_us,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  channel_index,
    output logic [10:0] raw_value,
    output logic [11:0] pulse_width,
    output logic        failsafe,
    output logic        signal_lost,
    output logic        last
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam logic [4:0] LAST_STORE_POS = 5'(STORE_DEPTH);

    state_t      state_reg, state_next;
    logic [4:0]  pos_reg, pos_next;
    logic [31:0] start_reg, start_next;
    logic [15:0] gap_reg, gap_next;
    logic [7:0]  flags_reg, flags_next;
    logic [17:0] acc_reg, acc_next;
    logic [4:0]  nbits_reg, nbits_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [4:0]  ch_reg, ch_next;
    logic [4:0]  idx_reg, idx_next;
    logic [10:0] raw_reg, raw_next;
    logic [11:0] pulse_reg, pulse_next;
    logic        last_reg, last_next;

    logic [31:0] diff;
    logic        gap_expired;
    logic [4:0]  pos_eff;
    logic        in_accept;
    logic        take;
    logic        frame_done;
    logic        ram_we;
    logic        ram_re;
    logic [AW-1:0] ram_waddr;
    logic [7:0]  ram_rd_data;
    logic [10:0] raw_sel;
    logic [13:0] times5;
    logic [4:0]  nbits_added;
    logic [4:0]  ch_inc;

    sbusrx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (rx_byte),
        .rd_en   (ram_re),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rd_data)
    );

    // Only a positive wrapped difference beyond the limit restarts the frame.
    assign diff        = time_us - start_reg;
    assign gap_expired = !diff[31] && (diff > {16'd0, gap_reg});
    assign pos_eff     = gap_expired ? 5'd0 : pos_reg;
    assign in_accept   = in_valid && !in_stall;
    assign take        = in_accept && (pos_eff != 5'd0 || rx_byte == START_BYTE)
                         && (pos_eff < FRAME_LEN);
    assign frame_done  = take && (pos_eff == FRAME_LEN - 5'd1);
    assign ram_waddr   = AW'(pos_eff - 5'd1);
    assign nbits_added = nbits_reg + 5'd8;
    assign ch_inc      = ch_reg + 5'd1;

    always_comb
    begin
        if (ch_reg < NUM_PACKED)
        begin
            raw_sel = acc_reg[CHAN_W-1:0];
        end
        else if (ch_reg == DIGITAL_CH_A)
        begin
            raw_sel = flags_reg[FLAG_CH16] ? DIGITAL_HIGH : DIGITAL_LOW;
        end
        else
        begin
            raw_sel = flags_reg[FLAG_CH17] ? DIGITAL_HIGH : DIGITAL_LOW;
        end
    end

    assign times5 = {3'b000, raw_sel} + {1'b0, raw_sel, 2'b00};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                state_next = (nbits_added >= 5'(CHAN_W)) ? ST_CALC : ST_READ;
            end
            ST_CALC:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (ch_inc >= NUM_PACKED || nbits_reg >= 5'(CHAN_W))
                    begin
                        state_next = ST_CALC;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and store control.
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        ram_re    = (state_reg == ST_READ);
        ram_we    = take && (pos_eff != 5'd0) && (pos_eff <= LAST_STORE_POS);
    end

    // Datapath.
    always_comb
    begin
        pos_next     = pos_reg;
        start_next   = start_reg;
        gap_next     = cfg_wr_en ? cfg_wr_data : gap_reg;
        flags_next   = flags_reg;
        acc_next     = acc_reg;
        nbits_next   = nbits_reg;
        rd_addr_next = rd_addr_reg;
        ch_next      = ch_reg;
        idx_next     = idx_reg;
        raw_next     = raw_reg;
        pulse_next   = pulse_reg;
        last_next    = last_reg;

        if (in_accept)
        begin
            pos_next = pos_eff;
        end
        if (take)
        begin
            if (pos_eff == 5'd0)
            begin
                start_next = time_us;
            end
            if (pos_eff == LAST_STORE_POS)
            begin
                flags_next = rx_byte;
            end
            pos_next = pos_eff + 5'd1;
        end
        if (frame_done)
        begin
            acc_next     = '0;
            nbits_next   = '0;
            rd_addr_next = '0;
            ch_next      = '0;
        end

        unique case (state_reg)
            ST_SHIFT:
            begin
                acc_next     = acc_reg | (18'(ram_rd_data) << nbits_reg);
                nbits_next   = nbits_added;
                rd_addr_next = rd_addr_reg + AW'(1);
            end
            ST_CALC:
            begin
                idx_next   = ch_reg;
                raw_next   = raw_sel;
                pulse_next = {1'b0, times5[13:3]} + PULSE_OFFSET;
                last_next  = (ch_reg == LAST_CHANNEL);
                if (ch_reg < NUM_PACKED)
                begin
                    acc_next   = acc_reg >> CHAN_W;
                    nbits_next = nbits_reg - 5'(CHAN_W);
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    ch_next = ch_inc;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            gap_reg   <= GAP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            gap_reg   <= gap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flags_reg   <= flags_next;
        acc_reg     <= acc_next;
        nbits_reg   <= nbits_next;
        rd_addr_reg <= rd_addr_next;
        ch_reg      <= ch_next;
        idx_reg     <= idx_next;
        raw_reg     <= raw_next;
        pulse_reg   <= pulse_next;
        last_reg    <= last_next;
    end

    assign channel_index = idx_reg;
    assign raw_value     = raw_reg;
    assign pulse_width   = pulse_reg;
    assign failsafe      = flags_reg[FLAG_FAILSAFE];
    assign signal_lost   = flags_reg[FLAG_SIGNAL_LOSS];
    assign last          = last_reg;

endmodule
